[src/cdo_pkg.sv]
package cdo_pkg;

    localparam int DAY_IN_W   = 5;
    localparam int MON_W      = 4;
    localparam int YEAR_IN_W  = 14;
    localparam int OFF_W      = 17;
    // working year: start year plus or minus the years one offset can span
    localparam int YEAR_W     = 16;
    localparam int YEAR_LIMIT = 9999;
    localparam int MONTHS     = 12;

    localparam logic [MON_W-1:0] MON_JAN = MON_W'(1);
    localparam logic [MON_W-1:0] MON_DEC = MON_W'(MONTHS);

    typedef struct packed {
        logic load;     // capture a new transaction
        logic step;     // one month of normalization
        logic publish;  // move the finished date to the output register
    } t_dp_cmd;

    typedef struct packed {
        logic need_fwd; // day beyond the current month
        logic need_bwd; // day below 1
    } t_dp_status;

    // days per month, 365-day year
    function automatic logic [DAY_IN_W-1:0] month_len(input logic [MON_W-1:0] m);
        logic [DAY_IN_W-1:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
            4'd2:                                      len = 5'd28;
            default:                                   len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

[src/calendar_date_offset_no_leap_top.sv]
// Date offset unit, fixed 365-day calendar (no leap years).
// Input channel: i_in_valid / o_in_stall carry one transaction of start day,
// month, year and a signed day offset. The offset is clamped to +/-MAX_OFFSET
// and a start month outside 1..12 is clamped to the nearest end.
// Output channel: o_out_valid / i_out_stall carry the resulting date and
// o_range_error, which flags a year that left 0..9999 (result saturated to
// Jan 1 year 0 at the low end, or Dec 31 year 9999 at the high end).
// Sequence: a load, then one month step per month boundary crossed, then
// the move into the output register. The month-step loop in the datapath
// does one subtract and compare per cycle. One transaction is in work at a
// time; o_in_stall is high from acceptance until the result is moved to the
// output register.
// A finished result waits in the output register while i_out_stall is high;
// the next transaction can be accepted and worked meanwhile, and holds in
// its final step until the output register frees up.
// Reset (synchronous, active low) returns the controller to idle and drops
// o_out_valid; datapath payload registers are not reset.
module calendar_date_offset_no_leap_top
    import cdo_pkg::*;
#(
    parameter int MAX_OFFSET = 65535
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // input channel
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [DAY_IN_W-1:0]     i_start_day,
    input  logic [MON_W-1:0]        i_start_month,
    input  logic [YEAR_IN_W-1:0]    i_start_year,
    input  logic signed [OFF_W-1:0] i_day_offset,
    // output channel
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [DAY_IN_W-1:0]     o_result_day,
    output logic [MON_W-1:0]        o_result_month,
    output logic [YEAR_IN_W-1:0]    o_result_year,
    output logic                    o_range_error
);

    // controller <-> datapath
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // sequencer: idle / run, owns both handshakes
    cdo_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (dp_cmd),
        .i_status    (dp_status)
    );

    // working date registers, month step unit, output register
    cdo_datapath #(
        .MAX_OFFSET (MAX_OFFSET)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_cmd          (dp_cmd),
        .o_status       (dp_status),
        .i_start_day    (i_start_day),
        .i_start_month  (i_start_month),
        .i_start_year   (i_start_year),
        .i_day_offset   (i_day_offset),
        .o_result_day   (o_result_day),
        .o_result_month (o_result_month),
        .o_result_year  (o_result_year),
        .o_range_error  (o_range_error)
    );

endmodule

[src/cdo_ctrl.sv]
module cdo_ctrl
    import cdo_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_dp_cmd    o_cmd,
    input  t_dp_status i_status
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                if (i_status.need_fwd || i_status.need_bwd) begin
                    o_cmd.step = 1'b1;
                end else if (out_free) begin
                    o_cmd.publish = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[src/cdo_datapath.sv]
module cdo_datapath
    import cdo_pkg::*;
#(
    parameter int MAX_OFFSET = 65535
) (
    input  logic                  i_clk,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    input  logic [DAY_IN_W-1:0]   i_start_day,
    input  logic [MON_W-1:0]      i_start_month,
    input  logic [YEAR_IN_W-1:0]  i_start_year,
    input  logic signed [OFF_W-1:0] i_day_offset,
    output logic [DAY_IN_W-1:0]   o_result_day,
    output logic [MON_W-1:0]      o_result_month,
    output logic [YEAR_IN_W-1:0]  o_result_year,
    output logic                  o_range_error
);

    localparam int MAG_W = ($clog2(MAX_OFFSET + 1) > OFF_W) ? $clog2(MAX_OFFSET + 1) : OFF_W;
    localparam int DAY_W = MAG_W + 2;
    localparam logic signed [DAY_W-1:0]  MAX_C   = DAY_W'(MAX_OFFSET);
    localparam logic signed [DAY_W-1:0]  MIN_C   = -MAX_C;
    localparam logic signed [YEAR_W-1:0] YEAR_HI = YEAR_W'(YEAR_LIMIT);

    logic signed [DAY_W-1:0]  r_day;
    logic [MON_W-1:0]         r_month;
    logic signed [YEAR_W-1:0] r_year;

    logic [DAY_IN_W-1:0]      r_res_day;
    logic [MON_W-1:0]         r_res_month;
    logic [YEAR_IN_W-1:0]     r_res_year;
    logic                     r_res_err;

    logic [MON_W-1:0]         mon_clamp;
    logic signed [DAY_W-1:0]  off_ext, off_sat;
    logic [MON_W-1:0]         prev_month;
    logic signed [DAY_W-1:0]  cur_len, prev_len;

    always_comb begin
        if (i_start_month < MON_JAN)      mon_clamp = MON_JAN;
        else if (i_start_month > MON_DEC) mon_clamp = MON_DEC;
        else                              mon_clamp = i_start_month;

        off_ext = DAY_W'(i_day_offset);
        if (off_ext > MAX_C)      off_sat = MAX_C;
        else if (off_ext < MIN_C) off_sat = MIN_C;
        else                      off_sat = off_ext;

        prev_month = (r_month == MON_JAN) ? MON_DEC : r_month - MON_W'(1);
        cur_len    = $signed(DAY_W'(month_len(r_month)));
        prev_len   = $signed(DAY_W'(month_len(prev_month)));
    end

    assign o_status.need_fwd = (r_day > cur_len);
    assign o_status.need_bwd = (r_day < $signed(DAY_W'(1)));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_day   <= $signed(DAY_W'(i_start_day)) + off_sat;
            r_month <= mon_clamp;
            r_year  <= $signed(YEAR_W'(i_start_year));
        end else if (i_cmd.step) begin
            if (o_status.need_fwd) begin
                r_day <= r_day - cur_len;
                if (r_month == MON_DEC) begin
                    r_month <= MON_JAN;
                    r_year  <= r_year + YEAR_W'(1);
                end else begin
                    r_month <= r_month + MON_W'(1);
                end
            end else begin
                r_day   <= r_day + prev_len;
                r_month <= prev_month;
                if (r_month == MON_JAN) r_year <= r_year - YEAR_W'(1);
            end
        end

        if (i_cmd.publish) begin
            if (r_year[YEAR_W-1]) begin
                r_res_day   <= DAY_IN_W'(1);
                r_res_month <= MON_JAN;
                r_res_year  <= '0;
                r_res_err   <= 1'b1;
            end else if (r_year > YEAR_HI) begin
                r_res_day   <= DAY_IN_W'(31);
                r_res_month <= MON_DEC;
                r_res_year  <= YEAR_IN_W'(YEAR_LIMIT);
                r_res_err   <= 1'b1;
            end else begin
                r_res_day   <= r_day[DAY_IN_W-1:0];
                r_res_month <= r_month;
                r_res_year  <= r_year[YEAR_IN_W-1:0];
                r_res_err   <= 1'b0;
            end
        end
    end

    assign o_result_day   = r_res_day;
    assign o_result_month = r_res_month;
    assign o_result_year  = r_res_year;
    assign o_range_error  = r_res_err;

endmodule

[src/cdo_checker.sv]
module cdo_checker
    import cdo_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_stall,
    input logic [DAY_IN_W-1:0]     i_start_day,
    input logic [MON_W-1:0]        i_start_month,
    input logic [YEAR_IN_W-1:0]    i_start_year,
    input logic signed [OFF_W-1:0] i_day_offset,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input logic [DAY_IN_W-1:0]     o_result_day,
    input logic [MON_W-1:0]        o_result_month,
    input logic [YEAR_IN_W-1:0]    o_result_year,
    input logic                    o_range_error
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // an accepted transaction makes the unit busy next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("unit not busy after accepting a transaction");

    // normal results are normalized dates in range
    a_result_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_range_error |->
            o_result_month >= MON_JAN && o_result_month <= MON_DEC &&
            o_result_day != '0 && o_result_year <= YEAR_IN_W'(YEAR_LIMIT))
        else $error("result date not normalized");

    // range errors saturate to one of the two end dates
    a_result_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_range_error |->
            (o_result_year == '0 && o_result_month == MON_JAN &&
             o_result_day == DAY_IN_W'(1)) ||
            (o_result_year == YEAR_IN_W'(YEAR_LIMIT) && o_result_month == MON_DEC &&
             o_result_day == DAY_IN_W'(31)))
        else $error("range error without saturated date");

endmodule

bind calendar_date_offset_no_leap_top cdo_checker u_cdo_checker (.*);

[verif/calendar_date_offset_no_leap_top_tb.sv]
// Date offset unit testbench: directed corner dates, then random dates and offsets
// under four flow-control phases. Results are checked in order against a
// shadow calendar computed in the testbench.
module calendar_date_offset_no_leap_top_tb;
    import cdo_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SHIFT   = 65535;
    localparam int RAND_ITEMS  = 250;
    localparam int MAX_REPORTS = 10;
    // quiet window after the last result
    localparam int TAIL_CYCLES = 2500;

    // one finished date as the output channel presents it
    typedef struct packed {
        logic [DAY_IN_W-1:0]  day;
        logic [MON_W-1:0]     month;
        logic [YEAR_IN_W-1:0] year;
        logic                 range_err;
    } t_date;

    // Shadow calendar plus the in-order list of dates still owed by the block.
    class date_ledger;
        t_date awaited[$];
        int    mismatch_count;

        function int month_days(int m);
            case (m)
                2:               return 28;
                4, 6, 9, 11:     return 30;
                default:         return 31;
            endcase
        endfunction

        // walk the date month by month, same as the hardware does
        function t_date move_date(logic [DAY_IN_W-1:0] d, logic [MON_W-1:0] m,
                                  logic [YEAR_IN_W-1:0] y,
                                  logic signed [OFF_W-1:0] shift);
            int    day;
            int    mon;
            int    yr;
            int    ofs;
            t_date r;
            day = d;
            mon = m;
            yr  = y;
            ofs = shift;
            if (mon < 1)
                mon = 1;
            if (mon > MONTHS)
                mon = MONTHS;
            if (ofs > MAX_SHIFT)
                ofs = MAX_SHIFT;
            if (ofs < -MAX_SHIFT)
                ofs = -MAX_SHIFT;
            day += ofs;
            while (day > month_days(mon)) begin
                day -= month_days(mon);
                mon++;
                if (mon > MONTHS) begin
                    mon = 1;
                    yr++;
                end
            end
            // day 0 is pulled back too, not just negative days
            while (day < 1) begin
                mon--;
                if (mon < 1) begin
                    mon = MONTHS;
                    yr--;
                end
                day += month_days(mon);
            end
            r.range_err = 1'b0;
            if (yr < 0) begin
                day = 1;
                mon = 1;
                yr  = 0;
                r.range_err = 1'b1;
            end else if (yr > YEAR_LIMIT) begin
                day = 31;
                mon = 12;
                yr  = YEAR_LIMIT;
                r.range_err = 1'b1;
            end
            r.day   = DAY_IN_W'(day);
            r.month = MON_W'(mon);
            r.year  = YEAR_IN_W'(yr);
            return r;
        endfunction

        function void log_request(logic [DAY_IN_W-1:0] d, logic [MON_W-1:0] m,
                                  logic [YEAR_IN_W-1:0] y,
                                  logic signed [OFF_W-1:0] shift);
            awaited.push_back(move_date(d, m, y, shift));
        endfunction

        function void match_result(t_date got);
            t_date want;
            bit    bad;
            if (awaited.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected result day %0d month %0d year %0d err %0b",
                             $time, got.day, got.month, got.year, got.range_err);
                return;
            end
            want = awaited.pop_front();
            bad = (got.day != want.day) || (got.month != want.month) ||
                  (got.year != want.year) || (got.range_err != want.range_err);
            if (bad) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: mismatch: expected %0d/%0d/%0d err %0b, got %0d/%0d/%0d err %0b",
                             $time, want.day, want.month, want.year, want.range_err,
                             got.day, got.month, got.year, got.range_err);
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic [DAY_IN_W-1:0]     i_start_day;
    logic [MON_W-1:0]        i_start_month;
    logic [YEAR_IN_W-1:0]    i_start_year;
    logic signed [OFF_W-1:0] i_day_offset;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic [DAY_IN_W-1:0]     o_result_day;
    logic [MON_W-1:0]        o_result_month;
    logic [YEAR_IN_W-1:0]    o_result_year;
    logic                    o_range_error;

    date_ledger ledger;

    // percent chance per cycle of the sender holding off / the receiver stalling
    int sender_idle_pct;
    int recv_stall_pct;

    calendar_date_offset_no_leap_top #(
        .MAX_OFFSET(MAX_SHIFT)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_start_day    (i_start_day),
        .i_start_month  (i_start_month),
        .i_start_year   (i_start_year),
        .i_day_offset   (i_day_offset),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result_day   (o_result_day),
        .o_result_month (o_result_month),
        .o_result_year  (o_result_year),
        .o_range_error  (o_range_error)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Receiver: stall decided at each falling edge, so it is settled by the
    // rising edge where the output transaction is sampled.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Output monitor: a transaction completes on valid && !stall at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            ledger.match_result('{o_result_day, o_result_month, o_result_year, o_range_error});
    end

    // Present one date; random hold-off first, then hold the payload until taken.
    task automatic send_date(logic [DAY_IN_W-1:0] d, logic [MON_W-1:0] m,
                             logic [YEAR_IN_W-1:0] y, logic signed [OFF_W-1:0] shift);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_start_day   <= d;
        i_start_month <= m;
        i_start_year  <= y;
        i_day_offset  <= shift;
        i_in_valid    <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        ledger.log_request(d, m, y, shift);
    endtask

    // Sender goes quiet until every owed date has come out.
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (ledger.pending() != 0)
            @(negedge i_clk);
    endtask

    // Mostly legal dates and short offsets (short month walks); a few
    // out-of-range fields and a few offsets at or past the clamp.
    task automatic send_random();
        logic [DAY_IN_W-1:0]     d;
        logic [MON_W-1:0]        m;
        logic [YEAR_IN_W-1:0]    y;
        logic signed [OFF_W-1:0] shift;
        int                      sel;
        d = ($urandom_range(0, 99) < 90) ? DAY_IN_W'($urandom_range(1, 31))
                                         : DAY_IN_W'($urandom_range(0, 31));
        m = ($urandom_range(0, 99) < 90) ? MON_W'($urandom_range(1, 12))
                                         : MON_W'($urandom_range(0, 15));
        y = ($urandom_range(0, 99) < 85) ? YEAR_IN_W'($urandom_range(0, 9999))
                                         : YEAR_IN_W'($urandom_range(0, 16383));
        sel = $urandom_range(0, 99);
        if (sel < 70)
            shift = OFF_W'(int'($urandom_range(0, 800)) - 400);
        else if (sel < 88)
            shift = OFF_W'(int'($urandom_range(0, 10000)) - 5000);
        else if (sel < 94) begin
            shift = OFF_W'(MAX_SHIFT - int'($urandom_range(0, 600)));
            if ($urandom_range(0, 1))
                shift = -shift;
            if ($urandom_range(0, 9) == 0)
                shift = OFF_W'(-65536);
        end else
            shift = OFF_W'($urandom);
        send_date(d, m, y, shift);
        // now and then let the pipe run dry mid-phase
        if ($urandom_range(0, 99) < 3)
            drain();
    endtask

    initial begin
        ledger = new();
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_start_day   = '0;
        i_start_month = '0;
        i_start_year  = '0;
        i_day_offset  = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners, back to back
        send_date(5'd1,  4'd1,  14'd0,     17'sd0);
        send_date(5'd31, 4'd12, 14'd9999,  17'sd1);       // year overflow
        send_date(5'd1,  4'd1,  14'd0,     -17'sd1);      // year underflow
        send_date(5'd31, 4'd12, 14'd9998,  17'sd1);       // carry into last legal year
        send_date(5'd1,  4'd1,  14'd1,     -17'sd1);      // borrow into year 0
        send_date(5'd0,  4'd3,  14'd2000,  17'sd0);       // day 0 -> end of Feb
        send_date(5'd0,  4'd1,  14'd0,     17'sd0);       // day 0 of year 0 underflows
        send_date(5'd31, 4'd2,  14'd2001,  17'sd0);       // day past month length
        send_date(5'd15, 4'd0,  14'd100,   17'sd0);       // month 0 clamps to Jan
        send_date(5'd15, 4'd13, 14'd100,   17'sd0);       // month 13 clamps to Dec
        send_date(5'd15, 4'd15, 14'd100,   17'sd20);
        send_date(5'd28, 4'd2,  14'd2023,  17'sd1);
        send_date(5'd1,  4'd3,  14'd2024,  -17'sd1);
        send_date(5'd1,  4'd1,  14'd1,     17'sd365);
        send_date(5'd1,  4'd1,  14'd5000,  17'sd65535);   // largest forward walk
        send_date(5'd31, 4'd12, 14'd5000,  -17'sd65535);  // largest backward walk
        send_date(5'd1,  4'd1,  14'd5000,  -17'sd65536);  // offset clamps
        send_date(5'd1,  4'd1,  14'd9900,  17'sd65535);   // overflow after a long walk
        send_date(5'd1,  4'd1,  14'd100,   -17'sd65536);  // underflow after a long walk
        send_date(5'd1,  4'd1,  14'd16383, 17'sd0);       // start year past 9999
        send_date(5'd1,  4'd1,  14'd10000, -17'sd365);    // back into range
        send_date(5'd31, 4'd15, 14'd16383, 17'sd65535);   // day, month and year bits all high
        send_date(5'd0,  4'd0,  14'd0,     -17'sd65536);
        drain();

        // random part: no idling, sender idle, receiver stall, both light
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 78; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 78; end
                default: begin sender_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            repeat (RAND_ITEMS / 4)
                send_random();
            drain();
        end

        // nothing owed now; keep watching for strays over a full walk's latency
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (ledger.mismatch_count == 0 && ledger.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #30_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
